// File: rtl/core/tbd_pkg.sv
// shared constants and codes for the terminated block dedup engine
package tbd_pkg;

   localparam int DEF_MAX_UNIQUE = 256;
   localparam int DEF_MAX_WORDS  = 64;

   localparam int WORD_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 8;
   localparam int BWORDS_W  = 7;
   localparam int FREED_W   = 24;
   localparam int CSR_IDX_W = 1;

   localparam logic [WORD_W-1:0]  TERMINATOR_RESET = 32'd2121494370;
   localparam logic [WORD_W-1:0]  BASE_RESET       = 32'd0;
   localparam logic [FREED_W-1:0] FREED_MAX        = 24'hFFFFFF;

   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_TERMINATOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE       = 1'd1;

endpackage

// File: rtl/core/tbd_cur_buf.sv
// current block buffer: collects words of the open block, tracks length and overflow
module tbd_cur_buf
   import tbd_pkg::*;
#(
   parameter int MAX_WORDS = DEF_MAX_WORDS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push_en,
   input  logic [WORD_W-1:0]                  push_data,
   input  logic                               clear_en,
   input  logic                               rd_en,
   input  logic [$clog2(MAX_WORDS)-1:0]       rd_addr,
   output logic [WORD_W-1:0]                  rd_data,
   output logic [$clog2(MAX_WORDS+1)-1:0]     cur_len,
   output logic                               overlong
);

   localparam int LW = $clog2(MAX_WORDS + 1);
   localparam int WW = $clog2(MAX_WORDS);

   logic [WORD_W-1:0] buf_mem [MAX_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [LW-1:0]     len_ff, len_in;
   logic              over_ff, over_in;
   logic              has_room;

   assign has_room = (len_ff < LW'(MAX_WORDS));

   always_comb begin
      len_in  = len_ff;
      over_in = over_ff;
      if (clear_en) begin
         len_in  = '0;
         over_in = 1'b0;
      end else if (push_en) begin
         if (has_room) begin
            len_in = len_ff + LW'(1);
         end else begin
            over_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         over_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         over_ff <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && has_room) begin
         buf_mem[len_ff[WW-1:0]] <= push_data;
      end
      if (rd_en) begin
         rd_data_ff <= buf_mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign cur_len  = len_ff;
   assign overlong = over_ff;

endmodule

// File: rtl/core/tbd_table.sv
// unique block table: word store plus per-entry length and offset
module tbd_table
   import tbd_pkg::*;
#(
   parameter int MAX_UNIQUE = DEF_MAX_UNIQUE,
   parameter int MAX_WORDS  = DEF_MAX_WORDS
) (
   input  logic                                      clock,
   input  logic                                      store_re,
   input  logic [$clog2(MAX_UNIQUE*MAX_WORDS)-1:0]   store_raddr,
   output logic [WORD_W-1:0]                         store_rdata,
   input  logic                                      store_we,
   input  logic [$clog2(MAX_UNIQUE*MAX_WORDS)-1:0]   store_waddr,
   input  logic [WORD_W-1:0]                         store_wdata,
   input  logic                                      ent_re,
   input  logic [$clog2(MAX_UNIQUE)-1:0]             ent_raddr,
   output logic [$clog2(MAX_WORDS+1)-1:0]            len_rdata,
   output logic [WORD_W-1:0]                         off_rdata,
   input  logic                                      ent_we,
   input  logic [$clog2(MAX_UNIQUE)-1:0]             ent_waddr,
   input  logic [$clog2(MAX_WORDS+1)-1:0]            len_wdata,
   input  logic [WORD_W-1:0]                         off_wdata
);

   localparam int LW    = $clog2(MAX_WORDS + 1);
   localparam int DEPTH = MAX_UNIQUE * MAX_WORDS;

   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [LW-1:0]     len_mem   [MAX_UNIQUE];
   logic [WORD_W-1:0] off_mem   [MAX_UNIQUE];

   logic [WORD_W-1:0] store_rdata_ff;
   logic [LW-1:0]     len_rdata_ff;
   logic [WORD_W-1:0] off_rdata_ff;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      if (store_re) begin
         store_rdata_ff <= store_mem[store_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         len_mem[ent_waddr] <= len_wdata;
      end
      if (ent_re) begin
         len_rdata_ff <= len_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         off_mem[ent_waddr] <= off_wdata;
      end
      if (ent_re) begin
         off_rdata_ff <= off_mem[ent_raddr];
      end
   end

   assign store_rdata = store_rdata_ff;
   assign len_rdata   = len_rdata_ff;
   assign off_rdata   = off_rdata_ff;

endmodule

// File: rtl/core/terminated_block_dedup.sv
// terminated block dedup top: sequencer, counters and result register
//
//   channel  direction  ports                                    handshake
//   req      in         req_data_word                            req_valid / req_ready
//   rsp      out        rsp_status .. rsp_freed_words            rsp_valid / rsp_ready
//   csr      in         csr_index, csr_wdata                     csr_we, no wait
//
// a word that is not the terminator goes into the buffer and gives no item
// a terminator is accepted, then for each stored entry its length is read and, when the
// lengths agree, its words are compared; at the table end a new block is copied into the
// store if there is room, then the result register is loaded; an overlong block skips the walk
// reset is synchronous; the tables need no clearing, only the counters and control state are reset
// a pending result does not stop word intake; a finished block waits until the slot is free
module terminated_block_dedup
   import tbd_pkg::*;
#(
   parameter int MAX_UNIQUE = DEF_MAX_UNIQUE,
   parameter int MAX_WORDS  = DEF_MAX_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_W-1:0]     req_data_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]    rsp_unique_index,
   output logic [WORD_W-1:0]     rsp_block_offset,
   output logic [BWORDS_W-1:0]   rsp_block_words,
   output logic [FREED_W-1:0]    rsp_freed_words,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]     csr_wdata
);

   localparam int LW = $clog2(MAX_WORDS + 1);
   localparam int WW = $clog2(MAX_WORDS);
   localparam int CW = $clog2(MAX_UNIQUE + 1);
   localparam int IW = $clog2(MAX_UNIQUE);
   localparam int AW = $clog2(MAX_UNIQUE * MAX_WORDS);
   localparam int RW = $clog2(MAX_UNIQUE * MAX_WORDS + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,
      S_LCHK = 6'b000100,
      S_CMP  = 6'b001000,
      S_COPY = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [WORD_W-1:0]   term_ff, term_in;
   logic [WORD_W-1:0]   base_ff, base_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [WORD_W-1:0]   packed_ff, packed_in;
   logic [FREED_W-1:0]  freed_ff, freed_in;
   logic [LW-1:0]       blk_len_ff, blk_len_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [LW-1:0]       j_ff, j_in;
   logic [WW-1:0]       wj_ff, wj_in;
   logic                vld_ff, vld_in;
   logic                last_ff, last_in;

   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [INDEX_W-1:0]  pend_index_ff, pend_index_in;
   logic [WORD_W-1:0]   pend_off_ff, pend_off_in;
   logic [BWORDS_W-1:0] pend_words_ff, pend_words_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [WORD_W-1:0]   rsp_off_ff, rsp_off_in;
   logic [BWORDS_W-1:0] rsp_words_ff, rsp_words_in;
   logic [FREED_W-1:0]  rsp_freed_ff, rsp_freed_in;

   logic                push_en, clear_en, cur_re;
   logic [WW-1:0]       cur_raddr;
   logic [WORD_W-1:0]   cur_rdata;
   logic [LW-1:0]       cur_len;
   logic                overlong;

   logic                store_re, store_we, ent_re, ent_we;
   logic [AW-1:0]       store_raddr, store_waddr;
   logic [WORD_W-1:0]   store_rdata;
   logic [LW-1:0]       len_rdata;
   logic [WORD_W-1:0]   off_rdata;
   logic [WORD_W-1:0]   new_off;
   logic [FREED_W:0]    freed_sum;
   logic                is_term;

   tbd_cur_buf #(
      .MAX_WORDS (MAX_WORDS)
   ) u_cur_buf (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (req_data_word),
      .clear_en  (clear_en),
      .rd_en     (cur_re),
      .rd_addr   (cur_raddr),
      .rd_data   (cur_rdata),
      .cur_len   (cur_len),
      .overlong  (overlong)
   );

   tbd_table #(
      .MAX_UNIQUE (MAX_UNIQUE),
      .MAX_WORDS  (MAX_WORDS)
   ) u_table (
      .clock       (clock),
      .store_re    (store_re),
      .store_raddr (store_raddr),
      .store_rdata (store_rdata),
      .store_we    (store_we),
      .store_waddr (store_waddr),
      .store_wdata (cur_rdata),
      .ent_re      (ent_re),
      .ent_raddr   (idx_ff[IW-1:0]),
      .len_rdata   (len_rdata),
      .off_rdata   (off_rdata),
      .ent_we      (ent_we),
      .ent_waddr   (idx_ff[IW-1:0]),
      .len_wdata   (blk_len_ff),
      .off_wdata   (new_off)
   );

   assign is_term     = (req_data_word == term_ff);
   assign new_off     = base_ff + packed_ff;
   assign freed_sum   = {1'b0, freed_ff} + (FREED_W + 1)'(blk_len_ff);
   assign store_raddr = AW'(row_ff + RW'(j_ff));
   assign store_waddr = AW'(row_ff + RW'(wj_ff));
   assign cur_raddr   = j_ff[WW-1:0];

   always_comb begin
      state_in       = state_ff;
      term_in        = term_ff;
      base_in        = base_ff;
      cnt_in         = cnt_ff;
      packed_in      = packed_ff;
      freed_in       = freed_ff;
      blk_len_in     = blk_len_ff;
      idx_in         = idx_ff;
      row_in         = row_ff;
      j_in           = j_ff;
      wj_in          = wj_ff;
      vld_in         = vld_ff;
      last_in        = last_ff;
      pend_status_in = pend_status_ff;
      pend_index_in  = pend_index_ff;
      pend_off_in    = pend_off_ff;
      pend_words_in  = pend_words_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_words_in   = rsp_words_ff;
      rsp_freed_in   = rsp_freed_ff;
      req_ready      = 1'b0;
      push_en        = 1'b0;
      clear_en       = 1'b0;
      cur_re         = 1'b0;
      store_re       = 1'b0;
      store_we       = 1'b0;
      ent_re         = 1'b0;
      ent_we         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            REG_TERMINATOR: term_in = csr_wdata;
            REG_BASE:       base_in = csr_wdata;
            default:        ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!is_term) begin
                  push_en = 1'b1;
               end else if (overlong || cur_len == LW'(MAX_WORDS)) begin
                  clear_en       = 1'b1;
                  pend_status_in = ST_TOO_LONG;
                  pend_index_in  = '0;
                  pend_off_in    = '0;
                  pend_words_in  = '0;
                  state_in       = S_DONE;
               end else begin
                  // terminator goes into the buffer too, then the table walk starts
                  push_en    = 1'b1;
                  clear_en   = 1'b1;
                  blk_len_in = cur_len + LW'(1);
                  idx_in     = '0;
                  row_in     = '0;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == cnt_ff) begin
               if (cnt_ff == CW'(MAX_UNIQUE)) begin
                  pend_status_in = ST_FULL;
                  pend_index_in  = '0;
                  pend_off_in    = '0;
                  pend_words_in  = BWORDS_W'(blk_len_ff);
                  state_in       = S_DONE;
               end else begin
                  // row_ff now points at the free row for the new entry
                  j_in     = '0;
                  vld_in   = 1'b0;
                  state_in = S_COPY;
               end
            end else begin
               ent_re   = 1'b1;
               state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            if (len_rdata != blk_len_ff) begin
               idx_in   = idx_ff + CW'(1);
               row_in   = row_ff + RW'(MAX_WORDS);
               state_in = S_SCAN;
            end else begin
               j_in     = '0;
               vld_in   = 1'b0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // reads issue each cycle, the compare runs in the cycle after each read
            if (vld_ff && store_rdata != cur_rdata) begin
               vld_in   = 1'b0;
               idx_in   = idx_ff + CW'(1);
               row_in   = row_ff + RW'(MAX_WORDS);
               state_in = S_SCAN;
            end else if (vld_ff && last_ff) begin
               vld_in         = 1'b0;
               freed_in       = freed_sum[FREED_W] ? FREED_MAX : freed_sum[FREED_W-1:0];
               pend_status_in = ST_DUPLICATE;
               pend_index_in  = INDEX_W'(idx_ff);
               pend_off_in    = off_rdata;
               pend_words_in  = BWORDS_W'(blk_len_ff);
               state_in       = S_DONE;
            end else begin
               store_re = 1'b1;
               cur_re   = 1'b1;
               vld_in   = 1'b1;
               last_in  = (j_ff == blk_len_ff - LW'(1));
               j_in     = j_ff + LW'(1);
            end
         end
         S_COPY: begin
            store_we = vld_ff;
            if (j_ff < blk_len_ff) begin
               cur_re = 1'b1;
               vld_in = 1'b1;
               wj_in  = WW'(j_ff);
               j_in   = j_ff + LW'(1);
            end else begin
               vld_in = 1'b0;
               if (!vld_ff) begin
                  ent_we         = 1'b1;
                  cnt_in         = cnt_ff + CW'(1);
                  packed_in      = packed_ff + (WORD_W'(blk_len_ff) << 2);
                  pend_status_in = ST_NEW;
                  pend_index_in  = INDEX_W'(idx_ff);
                  pend_off_in    = new_off;
                  pend_words_in  = BWORDS_W'(blk_len_ff);
                  state_in       = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_index_in  = pend_index_ff;
               rsp_off_in    = pend_off_ff;
               rsp_words_in  = pend_words_ff;
               rsp_freed_in  = freed_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         term_ff      <= TERMINATOR_RESET;
         base_ff      <= BASE_RESET;
         cnt_ff       <= '0;
         packed_ff    <= '0;
         freed_ff     <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         packed_ff    <= packed_in;
         freed_ff     <= freed_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_len_ff     <= blk_len_in;
      idx_ff         <= idx_in;
      row_ff         <= row_in;
      j_ff           <= j_in;
      wj_ff          <= wj_in;
      last_ff        <= last_in;
      pend_status_ff <= pend_status_in;
      pend_index_ff  <= pend_index_in;
      pend_off_ff    <= pend_off_in;
      pend_words_ff  <= pend_words_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_off_ff     <= rsp_off_in;
      rsp_words_ff   <= rsp_words_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_unique_index = rsp_index_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_words  = rsp_words_ff;
   assign rsp_freed_words  = rsp_freed_ff;

endmodule
